// ===== hdl/page_alloc_pkg.sv =====
`timescale 1ns / 1ps

package page_alloc_pkg;

   // fixed field widths
   localparam int ADDR_W   = 56;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int REFCNT_W = 8;

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_USABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_TOP   = 2'd2;

   localparam logic [ADDR_W-1:0] MEMORY_BASE_RST  = 56'h0000_0080_000000;
   localparam logic [ADDR_W-1:0] FIRST_USABLE_RST = 56'h0000_0080_000000;
   localparam logic [ADDR_W-1:0] MEMORY_TOP_RST   = 56'h0000_0088_000000;

   // request codes
   localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_SHARE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_PAGE   = 3'd1,
      ST_BAD_ADDR  = 3'd2,
      ST_LIST_FULL = 3'd3,
      ST_COUNT_SAT = 3'd4
   } status_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] page_address;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   granted_address;
      logic [REFCNT_W-1:0] ref_count;
      logic                released;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] memory_base;
      logic [ADDR_W-1:0] first_usable;
      logic [ADDR_W-1:0] memory_top;
   } cfg_type;

endpackage

// ===== hdl/page_alloc_check.sv =====
`timescale 1ns / 1ps

module page_alloc_check
   import page_alloc_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int IDX_W      = $clog2(NUM_PAGES)
) (
   input  logic [ADDR_W-1:0] page_address,
   input  cfg_type           cfg,
   output logic              addr_ok,
   output logic [IDX_W-1:0]  page_idx
);

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] page_num;
   logic              aligned;
   logic              in_window;
   logic              in_table;

   always_comb begin
      offset    = page_address - cfg.memory_base;
      page_num  = offset >> PAGE_SHIFT;
      aligned   = (page_address[PAGE_SHIFT-1:0] == '0);
      in_window = (page_address >= cfg.first_usable) &&
                  (page_address >= cfg.memory_base) &&
                  (page_address < cfg.memory_top);
      in_table  = (page_num < ADDR_W'(NUM_PAGES));
      addr_ok   = aligned && in_window && in_table;
      page_idx  = page_num[IDX_W-1:0];
   end

endmodule

// ===== hdl/page_alloc_stack_mem.sv =====
`timescale 1ns / 1ps

module page_alloc_stack_mem #(
   parameter int NUM_PAGES = 32768,
   parameter int IDX_W     = $clog2(NUM_PAGES)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] wr_data
);

   // contents undefined until pushed; only slots below the fill level are used
   logic [IDX_W-1:0] stack_ram [NUM_PAGES];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/page_alloc_count_mem.sv =====
`timescale 1ns / 1ps

module page_alloc_count_mem #(
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8,
   parameter int IDX_W      = $clog2(NUM_PAGES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data,
   output logic                  busy
);

   logic [COUNT_BITS-1:0] count_ram [NUM_PAGES];
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic                  clr_busy_ff;
   logic                  clr_busy_in;
   logic [IDX_W-1:0]      clr_addr_ff;
   logic [IDX_W-1:0]      clr_addr_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;

   // clearing sweep after reset, one entry a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_W'(NUM_PAGES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      ram_we    = wr_en;
      ram_waddr = wr_addr;
      ram_wdata = wr_data;
      if (clr_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         count_ram[ram_waddr] <= ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// ===== hdl/page_allocator_with_refcount.sv =====
`timescale 1ns / 1ps
// result: an accepted item enters the exec state, which registers its result; a result still
//    stalled in the result register holds the next item in exec until it is taken
// one item at a time: no new item is taken while one is in exec, set by the read-then-write
//    turn on the count and free-list memories (lookup/read in idle, modify/write in exec)
// reset: synchronous; the count table is swept to zero after reset, during which no item
//    is taken (register writes are still taken); the free list starts empty

module page_allocator_with_refcount
   import page_alloc_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int FC_W  = $clog2(NUM_PAGES + 1);
   localparam int CNT_W = COUNT_BITS;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic                   csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_MEMORY_BASE:  cfg_in.memory_base  = pwdata[ADDR_W-1:0];
            CSR_FIRST_USABLE: cfg_in.first_usable = pwdata[ADDR_W-1:0];
            CSR_MEMORY_TOP:   cfg_in.memory_top   = pwdata[ADDR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.memory_base  <= MEMORY_BASE_RST;
         cfg_ff.first_usable <= FIRST_USABLE_RST;
         cfg_ff.memory_top   <= MEMORY_TOP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back, unmapped addresses read as zero
   always_comb begin
      unique case (csr_idx)
         CSR_MEMORY_BASE:  prdata = CSR_DATA_W'(cfg_ff.memory_base);
         CSR_FIRST_USABLE: prdata = CSR_DATA_W'(cfg_ff.first_usable);
         CSR_MEMORY_TOP:   prdata = CSR_DATA_W'(cfg_ff.memory_top);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------
   state_type         state_ff;
   state_type         state_in;
   logic [FC_W-1:0]   free_count_ff;
   logic [FC_W-1:0]   free_count_in;
   logic [FUNC_W-1:0] func_ff;
   logic [FUNC_W-1:0] func_in;
   logic              addr_ok_ff;
   logic              addr_ok_in;
   logic [IDX_W-1:0]  page_idx_ff;
   logic [IDX_W-1:0]  page_idx_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              clr_busy;
   logic              req_take;
   logic              slot_free;
   logic              do_exec;

   // address check feeds the count table read address in the accept cycle
   logic              chk_ok;
   logic [IDX_W-1:0]  chk_idx;

   page_alloc_check #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .IDX_W      (IDX_W)
   ) u_check (
      .page_address (req_data.page_address),
      .cfg          (cfg_ff),
      .addr_ok      (chk_ok),
      .page_idx     (chk_idx)
   );

   // ---------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------
   logic             stk_we;
   logic [IDX_W-1:0] stk_waddr;
   logic [IDX_W-1:0] stk_raddr;
   logic [IDX_W-1:0] stk_rdata;
   logic [FC_W-1:0]  fc_minus_one;

   logic             cnt_we;
   logic [IDX_W-1:0] cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic [CNT_W-1:0] cnt_rdata;

   // top of stack is read on every accept so an allocate has it next cycle
   assign fc_minus_one = free_count_ff - 1'b1;
   assign stk_raddr    = fc_minus_one[IDX_W-1:0];

   page_alloc_stack_mem #(
      .NUM_PAGES (NUM_PAGES),
      .IDX_W     (IDX_W)
   ) u_stack (
      .clock   (clock),
      .rd_en   (req_take),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (page_idx_ff)
   );

   page_alloc_count_mem #(
      .NUM_PAGES  (NUM_PAGES),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_counts (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (chk_idx),
      .rd_data (cnt_rdata),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .busy    (clr_busy)
   );

   // ---------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE) || clr_busy;
   assign req_take  = req_valid && !req_stall;
   // result register is free, or is being emptied this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign do_exec   = (state_ff == S_EXEC) && slot_free;

   // ---------------------------------------------------------------
   // modify and write-back
   // ---------------------------------------------------------------
   logic             list_empty;
   logic             list_full;
   logic [CNT_W-1:0] cnt_new;
   logic [CNT_W+REFCNT_W-1:0] cnt_wide;

   assign list_empty = (free_count_ff == '0);
   assign list_full  = (free_count_ff == FC_W'(NUM_PAGES));

   always_comb begin
      stk_we        = 1'b0;
      stk_waddr     = free_count_ff[IDX_W-1:0];
      cnt_we        = 1'b0;
      cnt_waddr     = page_idx_ff;
      cnt_wdata     = cnt_rdata;
      cnt_new       = '0;
      free_count_in = free_count_ff;
      rsp_data_in   = rsp_data_ff;

      if (do_exec) begin
         rsp_data_in.status          = ST_OK;
         rsp_data_in.granted_address = '0;
         rsp_data_in.released        = 1'b0;

         case (func_ff)
            FN_ALLOC: begin
               if (list_empty) begin
                  rsp_data_in.status = ST_NO_PAGE;
               end else begin
                  // popped page starts with a single reference
                  cnt_new       = CNT_W'(1);
                  cnt_we        = 1'b1;
                  cnt_waddr     = stk_rdata;
                  free_count_in = fc_minus_one;
                  rsp_data_in.granted_address =
                     cfg_ff.memory_base + (ADDR_W'(stk_rdata) << PAGE_SHIFT);
               end
            end
            FN_FREE: begin
               if (!addr_ok_ff) begin
                  rsp_data_in.status = ST_BAD_ADDR;
               end else begin
                  // count saturates at zero, so fresh pages can be freed onto the list
                  cnt_new = (cnt_rdata == '0) ? '0 : cnt_rdata - 1'b1;
                  cnt_we  = 1'b1;
                  if (cnt_new == '0) begin
                     if (list_full) begin
                        rsp_data_in.status = ST_LIST_FULL;
                     end else begin
                        stk_we                = 1'b1;
                        free_count_in         = free_count_ff + 1'b1;
                        rsp_data_in.released  = 1'b1;
                     end
                  end
               end
            end
            FN_SHARE: begin
               if (!addr_ok_ff) begin
                  rsp_data_in.status = ST_BAD_ADDR;
               end else begin
                  cnt_we = 1'b1;
                  if (cnt_rdata == {CNT_W{1'b1}}) begin
                     cnt_new            = cnt_rdata;
                     rsp_data_in.status = ST_COUNT_SAT;
                  end else begin
                     cnt_new = cnt_rdata + 1'b1;
                  end
               end
            end
            default: begin
               // unused code: no state change, all-zero result
               rsp_data_in.status = ST_OK;
            end
         endcase

         cnt_wdata             = cnt_new;
         cnt_wide              = {{REFCNT_W{1'b0}}, cnt_new};
         rsp_data_in.ref_count = cnt_wide[REFCNT_W-1:0];
      end else begin
         cnt_wide = '0;
      end
   end

   // ---------------------------------------------------------------
   // sequencer: idle (accept, check, read) -> exec (modify, write, respond)
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      addr_ok_in  = addr_ok_ff;
      page_idx_in = page_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in    = S_EXEC;
               func_in     = req_data.func;
               addr_ok_in  = chk_ok;
               page_idx_in = chk_idx;
            end
         end
         S_EXEC: begin
            // stays here while the previous result is still held
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ok_ff  <= addr_ok_in;
      page_idx_ff <= page_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FC_W'(NUM_PAGES))
      else $error("free list fill level beyond capacity");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_EXEC))
      else $error("accepted item did not move to exec");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised outside exec");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.released) |->
         (rsp_data_ff.status == ST_OK && rsp_data_ff.ref_count == '0))
      else $error("release with bad status or live count");

endmodule

// ===== sim/page_alloc_checker.sv =====
`timescale 1ns / 1ps

module page_alloc_checker
   import page_alloc_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    error_count,
   output int                    replies_owed
);

   localparam int          IDX_W     = $clog2(NUM_PAGES);
   localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam int          MAX_SHOWN = 10;

   logic [ADDR_W-1:0]     cfg_base;
   logic [ADDR_W-1:0]     cfg_first;
   logic [ADDR_W-1:0]     cfg_top;
   logic [IDX_W-1:0]      free_stack [NUM_PAGES];
   logic [COUNT_BITS-1:0] page_refs [NUM_PAGES];
   int                    stack_depth;
   rsp_type               awaited_replies [$];
   int                    failures;
   int                    shown;

   // works out the reply to one request and updates the mirrored state
   function automatic rsp_type apply_request(input req_type r);
      rsp_type           reply;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] slot_addr;
      logic              addr_ok;
      logic [IDX_W-1:0]  slot;
      int unsigned       c;
      reply   = '0;
      offset  = r.page_address - cfg_base;
      addr_ok = (r.page_address[PAGE_SHIFT-1:0] == '0) && (r.page_address >= cfg_first) &&
                (r.page_address >= cfg_base) && (r.page_address < cfg_top) &&
                ((offset >> PAGE_SHIFT) < NUM_PAGES);
      slot    = offset[PAGE_SHIFT +: IDX_W];
      case (r.func)
         FN_ALLOC: begin
            if (stack_depth == 0) begin
               reply.status = ST_NO_PAGE;
            end else begin
               stack_depth--;
               slot                  = free_stack[stack_depth];
               page_refs[slot]       = COUNT_BITS'(1);
               slot_addr             = ADDR_W'(slot);
               reply.granted_address = cfg_base + (slot_addr << PAGE_SHIFT);
               reply.ref_count       = REFCNT_W'(1);
            end
         end
         FN_FREE: begin
            if (!addr_ok) begin
               reply.status = ST_BAD_ADDR;
            end else begin
               c = page_refs[slot];
               if (c > 0) c--;
               page_refs[slot] = COUNT_BITS'(c);
               reply.ref_count = REFCNT_W'(c);
               if (c == 0) begin
                  if (stack_depth >= NUM_PAGES) begin
                     reply.status = ST_LIST_FULL;
                  end else begin
                     free_stack[stack_depth] = slot;
                     stack_depth++;
                     reply.released = 1'b1;
                  end
               end
            end
         end
         FN_SHARE: begin
            if (!addr_ok) begin
               reply.status = ST_BAD_ADDR;
            end else begin
               c = page_refs[slot];
               if (c >= COUNT_MAX) begin
                  c            = COUNT_MAX;
                  reply.status = ST_COUNT_SAT;
               end else begin
                  c++;
               end
               page_refs[slot] = COUNT_BITS'(c);
               reply.ref_count = REFCNT_W'(c);
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_base    = MEMORY_BASE_RST;
         cfg_first   = FIRST_USABLE_RST;
         cfg_top     = MEMORY_TOP_RST;
         stack_depth = 0;
         failures    = 0;
         shown       = 0;
         for (int i = 0; i < NUM_PAGES; i++) page_refs[i] = '0;
         awaited_replies.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:3])
               CSR_MEMORY_BASE:  cfg_base  = pwdata[ADDR_W-1:0];
               CSR_FIRST_USABLE: cfg_first = pwdata[ADDR_W-1:0];
               CSR_MEMORY_TOP:   cfg_top   = pwdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               failures++;
               if (shown < MAX_SHOWN) begin
                  shown++;
                  $display("unexpected reply: status %0d granted %h count %0d released %0b",
                           rsp_data.status, rsp_data.granted_address, rsp_data.ref_count,
                           rsp_data.released);
               end
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.granted_address !== want.granted_address ||
                   rsp_data.ref_count !== want.ref_count ||
                   rsp_data.released !== want.released) begin
                  failures++;
                  if (shown < MAX_SHOWN) begin
                     shown++;
                     $display("reply mismatch at %0t ns", $realtime);
                     $display("  expected status %0d granted %h count %0d released %0b",
                              want.status, want.granted_address, want.ref_count,
                              want.released);
                     $display("  actual   status %0d granted %h count %0d released %0b",
                              rsp_data.status, rsp_data.granted_address, rsp_data.ref_count,
                              rsp_data.released);
                  end
               end
            end
         end
         if (req_valid && !req_stall) awaited_replies.push_back(apply_request(req_data));
      end
      error_count  <= failures;
      replies_owed <= awaited_replies.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import page_alloc_pkg::*;

   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;
   localparam int COUNT_BITS = 8;

   localparam int          PAGE_BYTES  = 1 << PAGE_SHIFT;
   localparam int          POOL_N      = 24;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // the package has no name for the spare request code
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int error_count;
   int replies_owed;

   // idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // copy of the settings last written, used only to aim addresses
   logic [ADDR_W-1:0] cur_base  = MEMORY_BASE_RST;
   logic [ADDR_W-1:0] cur_first = FIRST_USABLE_RST;
   logic [ADDR_W-1:0] cur_top   = MEMORY_TOP_RST;
   int unsigned       pool_lo   = 12;

   int unsigned cycles = 0;

   page_allocator_with_refcount #(
      .NUM_PAGES (NUM_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT),
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   page_alloc_checker #(
      .NUM_PAGES (NUM_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT),
      .COUNT_BITS(COUNT_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .error_count (error_count),
      .replies_owed(replies_owed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // hard stop in case the block hangs
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // round an address down to its page
   function automatic logic [ADDR_W-1:0] align_page(input logic [ADDR_W-1:0] a);
      return {a[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   endfunction

   // page holding slot i under the current base (base itself may be unaligned)
   function automatic logic [ADDR_W-1:0] page_of(input int unsigned i);
      return align_page(cur_base + (ADDR_W'(i) << PAGE_SHIFT));
   endfunction

   // all tasks start and end at a falling edge
   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_data.func         <= fn;
      req_data.page_address <= addr;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // drop valid and let every outstanding reply drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (replies_owed != 0) @(negedge clock);
   endtask

   // setup cycle then access cycle; psel stays high between back-to-back writes
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] first,
                             input logic [ADDR_W-1:0] top, input int unsigned lo);
      wait_idle();
      csr_write(CSR_MEMORY_BASE, base);
      csr_write(CSR_FIRST_USABLE, first);
      csr_write(CSR_MEMORY_TOP, top);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      cur_base  = base;
      cur_first = first;
      cur_top   = top;
      pool_lo   = lo;
   endtask

   // mostly pool pages so that frees and shares hit pages that really move,
   // with boundary, misaligned and wild addresses mixed in
   task automatic send_random();
      int unsigned       pick;
      logic [FUNC_W-1:0] fn;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      if (pick < 40)      fn = FN_ALLOC;
      else if (pick < 70) fn = FN_FREE;
      else if (pick < 92) fn = FN_SHARE;
      else                fn = FN_UNUSED;
      pick = $urandom_range(99);
      if (pick < 60) begin
         addr = page_of(pool_lo + $urandom_range(POOL_N - 1));
      end else if (pick < 72) begin
         case ($urandom_range(4))
            0:       addr = align_page(cur_first) - ADDR_W'(PAGE_BYTES);
            1:       addr = align_page(cur_top);
            2:       addr = align_page(cur_top - 1'b1);
            3:       addr = page_of(NUM_PAGES);
            default: addr = page_of(NUM_PAGES - 1);
         endcase
      end else if (pick < 84) begin
         addr = page_of(pool_lo + $urandom_range(POOL_N - 1)) |
                ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
      end else begin
         addr = ADDR_W'({$urandom, $urandom});
      end
      send_item(fn, addr);
   endtask

   task automatic run_random(input int n, input int unsigned idle, input int unsigned stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) send_random();
   endtask

   initial begin
      logic [ADDR_W-1:0] first_page;
      logic [ADDR_W-1:0] last_page;
      logic [ADDR_W-1:0] hot_page;

      // reset held, then released at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sixteen slots below the first usable page
      set_config(56'h80000000, 56'h80010000, 56'h88000000, 12);
      first_page = cur_first;
      last_page  = align_page(cur_top) - ADDR_W'(PAGE_BYTES);

      // directed: empty list, count up and down, double push, address checks
      send_item(FN_ALLOC, '0);
      send_item(FN_SHARE, first_page);
      send_item(FN_SHARE, first_page);
      send_item(FN_FREE, first_page);
      send_item(FN_FREE, first_page);
      send_item(FN_FREE, first_page);                       // free at zero pushes again
      send_item(FN_ALLOC, '0);
      send_item(FN_ALLOC, '1);
      send_item(FN_ALLOC, '0);                              // list empty again
      send_item(FN_FREE, first_page | ADDR_W'(PAGE_BYTES / 2));
      send_item(FN_FREE, first_page - ADDR_W'(PAGE_BYTES));
      send_item(FN_FREE, cur_top);
      send_item(FN_FREE, last_page);                        // highest slot
      send_item(FN_SHARE, '0);
      send_item(FN_SHARE, '1);
      send_item(FN_UNUSED, '1);
      send_item(FN_UNUSED, '0);
      send_item(FN_ALLOC, '0);
      send_item(FN_SHARE, last_page);
      send_item(FN_FREE, last_page);
      send_item(FN_FREE, first_page);
      send_item(FN_ALLOC, '1);

      // drive one page into saturation and all the way back
      hot_page = page_of(24);
      repeat (256) send_item(FN_SHARE, hot_page);
      repeat (257) send_item(FN_FREE, hot_page);

      // stock the free list from the usable pool slots, each page more than once
      for (int n = 0; n < 64; n++) send_item(FN_FREE, page_of(16 + n % 20));

      run_random(250, 0, 0);

      // widest window, table limit decides
      set_config('0, '0, '1, 12);
      run_random(250, 50, 0);

      // base near the top, so grants of stacked slots wrap
      set_config(56'hFF_FFFF_FFFF_0000, 56'hFF_FFFF_FFFF_0000, '1, 0);
      run_random(250, 0, 50);

      // unaligned base and a tight window
      set_config(56'h12_3456_789A_B800, 56'h12_3456_789A_E000, 56'h12_3456_789C_0000, 0);
      run_random(250, 28, 28);

      wait_idle();
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
